// ===== hw/rtl/csvs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared types and constants of the CSV last record id scanner.
// ----------------------------------------------------------------------------
package csvs_pkg;

  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam logic [31:0] MIN_SCHEMA_RESET = 32'd1;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_SPACE,
    CLS_PLUS,
    CLS_MINUS,
    CLS_COMMA,
    CLS_NEWLINE,
    CLS_NUL,
    CLS_OTHER
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic [3:0]  digit;
    logic        last;
  } token_t;

  typedef enum logic [2:0] {
    PH_SCH_LEAD,
    PH_SCH_NUM,
    PH_ID_START,
    PH_ID_LEAD,
    PH_ID_NUM,
    PH_DONE
  } phase_t;

endpackage
`default_nettype wire

// ===== hw/rtl/csvs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csvs_front
// Accepts window bytes and classifies each into a token for the queue.
// ----------------------------------------------------------------------------
module csvs_front import csvs_pkg::*; (
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            in_ready,
  input  wire logic       queue_full,
  output logic            push,
  output token_t          token
);

  always_comb begin
    in_ready    = !queue_full;
    push        = in_valid && !queue_full;
    token.digit = in_byte[3:0];
    token.last  = in_last;
    case (in_byte) inside
      8'h00:                                token.cls = CLS_NUL;
      8'h0A:                                token.cls = CLS_NEWLINE;
      8'h09, 8'h0B, 8'h0C, 8'h0D, 8'h20:    token.cls = CLS_SPACE;
      8'h2B:                                token.cls = CLS_PLUS;
      8'h2D:                                token.cls = CLS_MINUS;
      8'h2C:                                token.cls = CLS_COMMA;
      [8'h30:8'h39]:                        token.cls = CLS_DIGIT;
      default:                              token.cls = CLS_OTHER;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/csvs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csvs_queue
// Short token queue between the classifier and the line parser.
// ----------------------------------------------------------------------------
module csvs_queue import csvs_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire token_t push_token,
  output logic        full,
  input  wire logic   pop,
  output logic        not_empty,
  output token_t      head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  token_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_comb begin
    full      = (count == FULL_COUNT);
    not_empty = (count != '0);
    head      = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_token;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/csvs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csvs_back
// Line parser: runs the per-line field state and holds the window result.
// ----------------------------------------------------------------------------
module csvs_back import csvs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] min_schema,
  input  wire logic        tok_valid,
  input  wire token_t      tok,
  output logic             pop,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic             res_found,
  output logic [63:0]      res_id
);

  phase_t      phase,        phase_next;
  logic [31:0] sch_value,    sch_value_next;
  logic        sch_neg,      sch_neg_next;
  logic        sch_ovf,      sch_ovf_next;
  logic [63:0] id_value,     id_value_next;
  logic        id_neg,       id_neg_next;
  logic        id_ovf,       id_ovf_next;
  logic        has_digits,   has_digits_next;
  logic        rejected,     rejected_next;
  logic        any_found,    any_found_next;
  logic [63:0] last_id,      last_id_next;

  logic [35:0] sch_sum;
  logic [67:0] id_sum;
  logic [31:0] sch_signed;
  logic        load_res;
  logic        out_found;
  logic [63:0] out_id;

  always_comb begin
    sch_sum    = ({4'b0, sch_value} << 3) + ({4'b0, sch_value} << 1) + 36'(tok.digit);
    id_sum     = ({4'b0, id_value} << 3) + ({4'b0, id_value} << 1) + 68'(tok.digit);
    sch_signed = sch_neg ? (32'd0 - sch_value) : sch_value;
  end

  always_comb begin
    logic sch_step;
    logic idl_step;
    logic idn_step;

    sch_step        = 1'b0;
    idl_step        = 1'b0;
    idn_step        = 1'b0;
    phase_next      = phase;
    sch_value_next  = sch_value;
    sch_neg_next    = sch_neg;
    sch_ovf_next    = sch_ovf;
    id_value_next   = id_value;
    id_neg_next     = id_neg;
    id_ovf_next     = id_ovf;
    has_digits_next = has_digits;
    rejected_next   = rejected;
    any_found_next  = any_found;
    last_id_next    = last_id;
    out_found       = 1'b0;
    out_id          = '0;

    pop      = tok_valid && (!tok.last || !res_valid || res_ready);
    load_res = pop && tok.last;

    if (pop) begin
      if (tok.cls != CLS_NEWLINE && !rejected && phase != PH_DONE) begin
        if (tok.cls == CLS_NUL) begin
          rejected_next = 1'b1;
        end else begin
          case (phase)
            PH_SCH_LEAD: begin
              if (tok.cls == CLS_SPACE) begin
              end else if (tok.cls == CLS_PLUS || tok.cls == CLS_MINUS) begin
                sch_neg_next = (tok.cls == CLS_MINUS);
                phase_next   = PH_SCH_NUM;
              end else begin
                sch_step = 1'b1;
              end
            end
            PH_SCH_NUM:  sch_step = 1'b1;
            PH_ID_START: begin
              if (tok.cls == CLS_COMMA) begin
                id_value_next = '0;
                phase_next    = PH_DONE;
              end else begin
                idl_step = 1'b1;
              end
            end
            PH_ID_LEAD:  idl_step = 1'b1;
            PH_ID_NUM:   idn_step = 1'b1;
            default:     rejected_next = 1'b1;
          endcase

          if (sch_step) begin
            phase_next = PH_SCH_NUM;
            if (tok.cls == CLS_DIGIT) begin
              has_digits_next = 1'b1;
              if (|sch_sum[35:32]) begin
                sch_ovf_next = 1'b1;
              end else begin
                sch_value_next = sch_sum[31:0];
              end
            end else if (tok.cls == CLS_COMMA) begin
              if (!has_digits || sch_ovf || sch_signed == '0 || sch_signed < min_schema) begin
                rejected_next = 1'b1;
              end else begin
                phase_next      = PH_ID_START;
                has_digits_next = 1'b0;
              end
            end else begin
              rejected_next = 1'b1;
            end
          end

          if (idl_step) begin
            phase_next = PH_ID_LEAD;
            if (tok.cls == CLS_SPACE) begin
            end else if (tok.cls == CLS_PLUS || tok.cls == CLS_MINUS) begin
              id_neg_next = (tok.cls == CLS_MINUS);
              phase_next  = PH_ID_NUM;
            end else begin
              phase_next = PH_ID_NUM;
              idn_step   = 1'b1;
            end
          end

          if (idn_step) begin
            if (tok.cls == CLS_DIGIT) begin
              has_digits_next = 1'b1;
              if (|id_sum[67:64]) begin
                id_ovf_next = 1'b1;
              end else begin
                id_value_next = id_sum[63:0];
              end
            end else if (tok.cls == CLS_COMMA && has_digits && !id_ovf) begin
              id_value_next = id_neg ? (64'd0 - id_value) : id_value;
              phase_next    = PH_DONE;
            end else begin
              rejected_next = 1'b1;
            end
          end
        end
      end

      if (tok.cls == CLS_NEWLINE || tok.last) begin
        if (!rejected_next && phase_next == PH_DONE) begin
          any_found_next = 1'b1;
          last_id_next   = id_value_next;
        end
        phase_next      = PH_SCH_LEAD;
        sch_value_next  = '0;
        sch_neg_next    = 1'b0;
        sch_ovf_next    = 1'b0;
        id_value_next   = '0;
        id_neg_next     = 1'b0;
        id_ovf_next     = 1'b0;
        has_digits_next = 1'b0;
        rejected_next   = 1'b0;
      end

      if (tok.last) begin
        out_found      = any_found_next;
        out_id         = any_found_next ? last_id_next : '0;
        any_found_next = 1'b0;
        last_id_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SCH_LEAD;
      sch_value  <= '0;
      sch_neg    <= 1'b0;
      sch_ovf    <= 1'b0;
      id_value   <= '0;
      id_neg     <= 1'b0;
      id_ovf     <= 1'b0;
      has_digits <= 1'b0;
      rejected   <= 1'b0;
      any_found  <= 1'b0;
      last_id    <= '0;
      res_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      sch_value  <= sch_value_next;
      sch_neg    <= sch_neg_next;
      sch_ovf    <= sch_ovf_next;
      id_value   <= id_value_next;
      id_neg     <= id_neg_next;
      id_ovf     <= id_ovf_next;
      has_digits <= has_digits_next;
      rejected   <= rejected_next;
      any_found  <= any_found_next;
      last_id    <= last_id_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_found <= out_found;
      res_id    <= out_id;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/csv_last_record_id_scanner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csv_last_record_id_scanner
// Scans a log tail window byte by byte and reports the id of the last valid
// CSV line. A window's last byte is written into the token queue, and its result is then registered.
// Throughput: one byte per cycle, bounded by the single-step line parser, unless a last byte waits on m_axis_tready.
// Reset clears all scan state and the queue; the minimum schema becomes 1.
// ----------------------------------------------------------------------------
module csv_last_record_id_scanner import csvs_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [63:0] last valid line id
  output logic [0:0]       m_axis_tuser,   // [0] found
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0] min_schema;
  logic        queue_full;
  logic        push;
  token_t      push_token;
  logic        pop;
  logic        not_empty;
  token_t      head;
  logic        res_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_schema <= MIN_SCHEMA_RESET;
    end else if (cfg_we) begin
      min_schema <= cfg_wdata;
    end
  end

  csvs_front u_front (
    .in_valid   (s_axis_tvalid),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .in_ready   (s_axis_tready),
    .queue_full (queue_full),
    .push       (push),
    .token      (push_token)
  );

  csvs_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  csvs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .min_schema (min_schema),
    .tok_valid  (not_empty),
    .tok        (head),
    .pop        (pop),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_found  (res_found),
    .res_id     (m_axis_tdata)
  );

  assign m_axis_tuser = res_found;

endmodule
`default_nettype wire
